FILE: hw/rtl/assert_macros.svh
// Assertion macros shared by the checker modules.
// Each use expands to one labeled concurrent assertion on clk; CHK_ASSERT is held off in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising edge outside reset
`define CHK_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Same, checked during reset as well
`define CHK_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hw/rtl/dfsp_pkg.sv
// Package for the depth-first path search core: sizes and request codes.
// No dependencies.
package dfsp_pkg;

	// Graph and stack sizes
	localparam int NODES       = 16;
	localparam int NODE_W      = 4;
	localparam int STACK_DEPTH = 256;
	localparam int STACK_AW    = 8;
	localparam int SP_W        = 9;
	localparam int PATH_MAX    = 16;

	// Request codes
	localparam logic OP_LOAD   = 1'b0;
	localparam logic OP_SEARCH = 1'b1;

endpackage

FILE: hw/rtl/dfs_path_search_adjacency_core.sv
// Depth-first path search core: adjacency storage, walk sequencer, path output.
// Depends on dfsp_pkg.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one request per accept. A load
//   request (opcode OP_LOAD) writes one adjacency row and leaves the core ready
//   for the next request. A search request (opcode OP_SEARCH)
//   runs a stack walk from start_node and keeps in_stall high until its last
//   result has been placed in the output register.
//   A search pushes the start node, then pops the stack (stack RAM read is
//   registered), scans the neighbours of each newly visited node other than
//   the goal (one neighbour bit per cycle through the push unit), traces
//   parent links back from the goal, then places the results while the
//   receiver keeps up.
//   Output channel (out_valid / out_stall) presents path nodes from start to
//   goal, last set on the goal; a miss gives one result with found clear.
//   A stalled output holds its payload; the sequencer waits for the slot.
//   Reset (arst_n low) clears the sequencer, visited marks, parent valid marks and
//   the output valid; adjacency rows and the stack are not cleared.
module dfs_path_search_adjacency_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        opcode,
	input  logic [dfsp_pkg::NODE_W-1:0] row_index,
	input  logic [dfsp_pkg::NODES-1:0]  row_bits,
	input  logic [dfsp_pkg::NODE_W-1:0] start_node,
	input  logic [dfsp_pkg::NODE_W-1:0] goal_node,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [dfsp_pkg::NODE_W-1:0] path_node,
	output logic                        found,
	output logic                        last
);

	// Sequencer codes
	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_POP   = 3'd1;
	localparam logic [2:0] ST_CHECK = 3'd2;
	localparam logic [2:0] ST_SCAN  = 3'd3;
	localparam logic [2:0] ST_TRACE = 3'd4;
	localparam logic [2:0] ST_EMIT  = 3'd5;
	localparam logic [2:0] ST_MISS  = 3'd6;

	logic [2:0]                        state_q;
	logic [dfsp_pkg::SP_W-1:0]         sp_q;
	logic [dfsp_pkg::SP_W-1:0]         sp_dec;
	logic [dfsp_pkg::NODES-1:0]        visited_q;
	logic [dfsp_pkg::NODES-1:0]        pvalid_q;
	logic [dfsp_pkg::NODE_W-1:0]       parent_q [dfsp_pkg::NODES];
	logic [dfsp_pkg::NODES-1:0]        adj_q    [dfsp_pkg::NODES];
	logic [dfsp_pkg::NODE_W-1:0]       path_q   [dfsp_pkg::PATH_MAX];
	logic [dfsp_pkg::NODE_W-1:0]       stack_mem [dfsp_pkg::STACK_DEPTH];
	logic [dfsp_pkg::NODE_W-1:0]       stk_rd_q;
	logic [dfsp_pkg::NODE_W-1:0]       goal_q;
	logic [dfsp_pkg::NODE_W-1:0]       cur_q;
	logic [dfsp_pkg::NODES-1:0]        row_q;
	logic [dfsp_pkg::NODE_W-1:0]       nb_q;
	logic [dfsp_pkg::NODE_W-1:0]       at_q;
	logic [dfsp_pkg::NODE_W-1:0]       len_q;
	logic                              out_valid_q;
	logic [dfsp_pkg::NODE_W-1:0]       path_node_q;
	logic                              found_q;
	logic                              last_q;

	logic                              in_acc;
	logic                              out_free;
	logic                              stk_we;
	logic [dfsp_pkg::STACK_AW-1:0]     stk_wa;
	logic [dfsp_pkg::NODE_W-1:0]       stk_wd;
	logic                              push_ok;
	logic [dfsp_pkg::NODE_W-1:0]       cur_pop;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign sp_dec    = sp_q - dfsp_pkg::SP_W'(1);
	assign cur_pop   = stk_rd_q;

	assign out_valid = out_valid_q;
	assign path_node = path_node_q;
	assign found     = found_q;
	assign last      = last_q;

	// Push unit: one neighbour bit per cycle, dropped when the stack is full
	assign push_ok = row_q[nb_q] && !visited_q[nb_q]
		&& (sp_q != dfsp_pkg::SP_W'(dfsp_pkg::STACK_DEPTH));

	always_comb begin
		stk_we = 1'b0;
		stk_wa = sp_q[dfsp_pkg::STACK_AW-1:0];
		stk_wd = nb_q;
		if (state_q == ST_IDLE) begin
			stk_we = in_acc && (opcode == dfsp_pkg::OP_SEARCH);
			stk_wa = '0;
			stk_wd = start_node;
		end else if (state_q == ST_SCAN) begin
			stk_we = push_ok;
		end
	end

	// Walk stack memory, registered read
	always_ff @(posedge clk) begin
		if (stk_we) begin
			stack_mem[stk_wa] <= stk_wd;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_POP) begin
			stk_rd_q <= stack_mem[sp_dec[dfsp_pkg::STACK_AW-1:0]];
		end
	end

	// Payload storage: adjacency rows, parent nodes, path buffer, work registers
	always_ff @(posedge clk) begin
		if (in_acc && (opcode == dfsp_pkg::OP_LOAD)) begin
			adj_q[row_index] <= row_bits;
		end
		if (in_acc) begin
			goal_q <= goal_node;
		end
		if (state_q == ST_CHECK) begin
			cur_q <= cur_pop;
			row_q <= adj_q[cur_pop];
			nb_q  <= dfsp_pkg::NODE_W'(dfsp_pkg::NODES - 1);
			at_q  <= goal_q;
		end
		if (state_q == ST_SCAN) begin
			if (push_ok) begin
				parent_q[nb_q] <= cur_q;
			end
			nb_q <= nb_q - dfsp_pkg::NODE_W'(1);
		end
		if (state_q == ST_TRACE) begin
			path_q[len_q] <= at_q;
			at_q <= parent_q[at_q];
		end
	end

	// Sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			sp_q      <= '0;
			visited_q <= '0;
			pvalid_q  <= '0;
			len_q     <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_acc && (opcode == dfsp_pkg::OP_SEARCH)) begin
						visited_q <= '0;
						pvalid_q  <= '0;
						sp_q      <= dfsp_pkg::SP_W'(1);
						len_q     <= '0;
						state_q   <= ST_POP;
					end
				end
				ST_POP: begin
					if (sp_q == '0) begin
						state_q <= ST_MISS;
					end else begin
						sp_q    <= sp_dec;
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (visited_q[cur_pop]) begin
						state_q <= ST_POP;
					end else begin
						visited_q[cur_pop] <= 1'b1;
						state_q <= (cur_pop == goal_q) ? ST_TRACE : ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (push_ok) begin
						pvalid_q[nb_q] <= 1'b1;
						sp_q <= sp_q + dfsp_pkg::SP_W'(1);
					end
					if (nb_q == '0) begin
						state_q <= ST_POP;
					end
				end
				ST_TRACE: begin
					// walk back from the goal until the start (no parent) or a full path buffer
					if (!pvalid_q[at_q]
						|| (len_q == dfsp_pkg::NODE_W'(dfsp_pkg::PATH_MAX - 1))) begin
						state_q <= ST_EMIT;
					end else begin
						len_q <= len_q + dfsp_pkg::NODE_W'(1);
					end
				end
				ST_EMIT: begin
					// path buffer holds goal first, so emit from the top index down
					if (out_free) begin
						if (len_q == '0) begin
							state_q <= ST_IDLE;
						end else begin
							len_q <= len_q - dfsp_pkg::NODE_W'(1);
						end
					end
				end
				ST_MISS: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free && ((state_q == ST_EMIT) || (state_q == ST_MISS))) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && (state_q == ST_EMIT)) begin
			path_node_q <= path_q[len_q];
			found_q     <= 1'b1;
			last_q      <= (len_q == '0);
		end else if (out_free && (state_q == ST_MISS)) begin
			path_node_q <= '0;
			found_q     <= 1'b0;
			last_q      <= 1'b1;
		end
	end

endmodule

FILE: hw/rtl/dfsp_checker.sv
// Port-level checker for the depth-first path search core, bound to the core module.
// Depends on dfsp_pkg and assert_macros.svh.
`include "assert_macros.svh"

module dfsp_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_stall,
	input logic                        opcode,
	input logic                        out_valid,
	input logic                        out_stall,
	input logic [dfsp_pkg::NODE_W-1:0] path_node,
	input logic                        found,
	input logic                        last
);

	// A stalled result holds
	`CHK_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(path_node) && $stable(found) && $stable(last), "stalled result changed")

	// A miss is always a single, final result
	`CHK_ASSERT(a_miss_last, out_valid && !found |-> last, "miss result not marked last")

	// No new request while a search still has results to place
	`CHK_ASSERT(a_busy_mid_path, out_valid && !last |-> in_stall, "request taken mid path")

	// A search request makes the core busy on the next cycle
	`CHK_ASSERT(a_search_busy, in_valid && !in_stall && (opcode == dfsp_pkg::OP_SEARCH) |=> in_stall, "search did not hold the input")

	// A row load does not hold the input
	`CHK_ASSERT(a_load_quick, in_valid && !in_stall && (opcode == dfsp_pkg::OP_LOAD) |=> !in_stall, "row load held the input")

endmodule

bind dfs_path_search_adjacency_core dfsp_checker u_dfsp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.opcode    (opcode),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.path_node (path_node),
	.found     (found),
	.last      (last)
);
